[rtl/dersig_pkg.sv]
// Package for the DER ECDSA signature parser: phase and status codes,
// parser state struct and size limits. No dependencies.
`default_nettype none
package dersig_pkg;

    localparam logic [7:0] MAX_SIG_BYTES = 8'd72;
    localparam logic [7:0] MIN_SIG_BYTES = 8'd8;
    localparam logic [5:0] INT_BYTES     = 6'd32;
    localparam logic [7:0] MAX_INT_LEN   = 8'd33;
    localparam logic [7:0] SEQ_TAG       = 8'h30;
    localparam logic [7:0] INT_TAG       = 8'h02;
    localparam int         WORD_W        = 64;
    localparam int         NUM_WORDS     = 8;
    localparam int         INT_W         = 256;

    typedef enum logic [2:0] {
        PH_SEQ_TAG,
        PH_SEQ_LEN,
        PH_INT_TAG,
        PH_INT_LEN,
        PH_INT_FIRST,
        PH_INT_SECOND,
        PH_INT_REST,
        PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK,
        ST_SIZE,
        ST_SEQ_TAG,
        ST_SEQ_LEN,
        ST_INT_SHORT,
        ST_INT_TAG,
        ST_INT_LEN,
        ST_OVERRUN,
        ST_SIGN,
        ST_TOO_BIG,
        ST_TRAILING
    } t_status;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  byte_count;
        logic [7:0]  seq_len;
        logic [5:0]  bytes_left;
        logic [5:0]  int_len;
        logic        which_int;
        t_status     first_error;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:       PH_SEQ_TAG,
        byte_count:  8'd0,
        seq_len:     8'd0,
        bytes_left:  6'd0,
        int_len:     6'd0,
        which_int:   1'b0,
        first_error: ST_OK
    };

endpackage
`default_nettype wire

[rtl/dersig_step.sv]
// One-byte parser step: next parser state, shift strobe and final status.
// Pure combinational; depends on dersig_pkg.
`default_nettype none
module dersig_step (
    input  dersig_pkg::t_parse_state i_state,
    input  logic [7:0]               i_byte,
    output dersig_pkg::t_parse_state o_state,
    output logic                     o_shift,
    output dersig_pkg::t_status      o_status
);
    import dersig_pkg::*;

    logic [9:0] w_pos;
    logic [9:0] w_buf_end;
    logic [7:0] w_size;
    logic [5:0] w_left;
    logic       w_cons;
    logic       w_fail;
    t_status    w_code;
    t_parse_state w_n;

    assign w_pos     = {2'b00, i_state.byte_count};
    assign w_buf_end = {2'b00, i_state.seq_len} + 10'd2;

    always_comb begin
        w_n    = i_state;
        w_cons = 1'b0;
        w_fail = 1'b0;
        w_code = ST_OK;
        w_left = i_state.bytes_left;
        unique case (i_state.phase)
            PH_SEQ_TAG: begin
                if (i_byte != SEQ_TAG) begin
                    w_fail = 1'b1;
                    w_code = ST_SEQ_TAG;
                end else begin
                    w_n.phase = PH_SEQ_LEN;
                end
            end
            PH_SEQ_LEN: begin
                w_n.seq_len = i_byte;
                if (i_byte <= 8'd2) begin
                    w_fail = 1'b1;
                    w_code = ST_INT_SHORT;
                end else begin
                    w_n.phase = PH_INT_TAG;
                end
            end
            PH_INT_TAG: begin
                if (i_byte != INT_TAG) begin
                    w_fail = 1'b1;
                    w_code = ST_INT_TAG;
                end else begin
                    w_n.phase = PH_INT_LEN;
                end
            end
            PH_INT_LEN: begin
                if (i_byte == 8'd0 || i_byte > MAX_INT_LEN) begin
                    w_fail = 1'b1;
                    w_code = ST_INT_LEN;
                end else if (w_pos + 10'd1 + {2'b00, i_byte} > w_buf_end) begin
                    w_fail = 1'b1;
                    w_code = ST_OVERRUN;
                end else begin
                    w_n.int_len    = i_byte[5:0];
                    w_n.bytes_left = i_byte[5:0];
                    w_n.phase      = PH_INT_FIRST;
                end
            end
            PH_INT_FIRST: begin
                if (i_byte != 8'd0) begin
                    if (i_byte[7]) begin
                        w_fail = 1'b1;
                        w_code = ST_SIGN;
                    end else if (i_state.int_len > INT_BYTES) begin
                        w_fail = 1'b1;
                        w_code = ST_TOO_BIG;
                    end else begin
                        w_cons = 1'b1;
                    end
                end else if (i_state.int_len > 6'd1) begin
                    // leading zero pad: skip it, next byte must have MSB set
                    w_n.bytes_left = i_state.bytes_left - 6'd1;
                    w_n.phase      = PH_INT_SECOND;
                end else begin
                    w_cons = 1'b1;
                end
            end
            PH_INT_SECOND: begin
                if (!i_byte[7]) begin
                    w_fail = 1'b1;
                    w_code = ST_SIGN;
                end else if (i_state.int_len - 6'd1 > INT_BYTES) begin
                    w_fail = 1'b1;
                    w_code = ST_TOO_BIG;
                end else begin
                    w_cons = 1'b1;
                end
            end
            PH_INT_REST: w_cons = 1'b1;
            PH_DONE:     w_n = i_state;
            default:     w_n = i_state;
        endcase

        if (w_cons) begin
            if (w_left != 6'd0) begin
                w_left = w_left - 6'd1;
            end
            w_n.bytes_left = w_left;
            if (w_left != 6'd0) begin
                w_n.phase = PH_INT_REST;
            end else if (!i_state.which_int) begin
                if (w_pos + 10'd3 >= w_buf_end) begin
                    w_fail = 1'b1;
                    w_code = ST_INT_SHORT;
                end else begin
                    w_n.which_int = 1'b1;
                    w_n.phase     = PH_INT_TAG;
                end
            end else begin
                if (w_pos + 10'd1 != w_buf_end) begin
                    w_fail = 1'b1;
                    w_code = ST_TRAILING;
                end else begin
                    w_n.phase = PH_DONE;
                end
            end
        end

        if (w_fail) begin
            if (i_state.first_error == ST_OK) begin
                w_n.first_error = w_code;
            end
            w_n.phase = PH_DONE;
        end

        // saturating byte count, used for the size check
        if (i_state.byte_count != 8'hFF) begin
            w_n.byte_count = i_state.byte_count + 8'd1;
        end
    end

    assign w_size  = w_n.byte_count;
    assign o_state = w_n;
    assign o_shift = w_cons;

    always_comb begin
        priority if (w_size < MIN_SIG_BYTES || w_size > MAX_SIG_BYTES) begin
            o_status = ST_SIZE;
        end else if (w_n.first_error == ST_SEQ_TAG) begin
            o_status = ST_SEQ_TAG;
        end else if (w_n.seq_len != w_size - 8'd2) begin
            o_status = ST_SEQ_LEN;
        end else if (w_n.first_error != ST_OK) begin
            o_status = w_n.first_error;
        end else if (w_n.phase != PH_DONE) begin
            o_status = ST_TRAILING;
        end else begin
            o_status = ST_OK;
        end
    end

endmodule
`default_nettype wire

[rtl/der_ecdsa_signature_parser_unit.sv]
// Top level of the DER ECDSA signature parser: input register, parser
// step, r/s value registers and an 8-word result buffer.
// Depends on dersig_pkg and dersig_step.
//
// Usage:
//  - Slave channel (i_s_*): one signature byte per item, tlast on the
//    last byte of the signature buffer.
//  - Master channel (o_m_*): after each last byte, a run of eight items:
//    r words 0..3 then s words 4..7, most significant first, with the
//    parse status in tuser (same on all eight) and tlast on the eighth.
//    Words are zero when the status is not ok.
//  - Throughput: one byte per cycle through the combinational parser step,
//    except while a last byte waits. The result run drains from its own
//    buffer while the next signature is already being parsed; a last byte
//    waits in the input register only while the previous run is still in
//    the buffer.
//  - Result path: the last byte is accepted into the input register, then
//    parsed and loaded into the result buffer, where the first word shows.
//  - Stall: when i_m_tready is low the current word holds; bytes keep
//    flowing until a last byte finds the buffer still full.
//  - Reset (i_rst_n low, synchronous): parser to sequence-tag phase,
//    r/s cleared, input register and result buffer empty.
`default_nettype none
module der_ecdsa_signature_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // final_byte
    // master channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [63:0] value_word, [66:64] word_index, rest zero
    output logic [3:0]  o_m_tuser,   // [3:0] status
    output logic        o_m_tlast    // run_end
);
    import dersig_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parser state and integer registers
    t_parse_state r_state;
    t_parse_state n_state;
    logic [INT_W-1:0] r_int_r;
    logic [INT_W-1:0] r_int_s;
    logic [INT_W-1:0] n_int_r;
    logic [INT_W-1:0] n_int_s;

    // result buffer: word 0 is the one on the bus
    logic [WORD_W-1:0] r_ob_word [NUM_WORDS];
    logic [2:0]        r_ob_idx;
    logic              r_ob_valid;
    t_status           r_ob_status;

    logic    w_shift;
    t_status w_status;
    logic    w_m_hs;
    logic    w_ob_free;
    logic    w_adv;
    logic    w_load;

    dersig_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_shift  (w_shift),
        .o_status (w_status)
    );

    assign w_m_hs     = r_ob_valid && i_m_tready;
    assign w_ob_free  = !r_ob_valid || (w_m_hs && r_ob_idx == 3'd7);
    // a last byte only moves on once the buffer can take the run
    assign w_adv      = r_in_valid && (!r_in_last || w_ob_free);
    assign w_load     = w_adv && r_in_last;
    assign o_s_tready = !r_in_valid || w_adv;

    // byte shifts into r or s, least significant end
    always_comb begin
        n_int_r = r_int_r;
        n_int_s = r_int_s;
        if (w_shift) begin
            if (r_state.which_int) begin
                n_int_s = {r_int_s[INT_W-9:0], r_in_byte};
            end else begin
                n_int_r = {r_int_r[INT_W-9:0], r_in_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // parser; everything returns to reset after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_RESET;
            r_int_r <= '0;
            r_int_s <= '0;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_state <= PARSE_RESET;
                r_int_r <= '0;
                r_int_s <= '0;
            end else begin
                r_state <= n_state;
                r_int_r <= n_int_r;
                r_int_s <= n_int_s;
            end
        end
    end

    // result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_valid <= 1'b0;
            r_ob_idx   <= 3'd0;
        end else if (w_load) begin
            r_ob_valid <= 1'b1;
            r_ob_idx   <= 3'd0;
        end else if (w_m_hs) begin
            r_ob_idx <= r_ob_idx + 3'd1;
            if (r_ob_idx == 3'd7) begin
                r_ob_valid <= 1'b0;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ob_status <= w_status;
            for (int k = 0; k < NUM_WORDS / 2; k++) begin
                r_ob_word[k] <= (w_status == ST_OK) ?
                    n_int_r[INT_W-1-WORD_W*k -: WORD_W] : '0;
                r_ob_word[k+NUM_WORDS/2] <= (w_status == ST_OK) ?
                    n_int_s[INT_W-1-WORD_W*k -: WORD_W] : '0;
            end
        end else if (w_m_hs) begin
            for (int k = 0; k < NUM_WORDS - 1; k++) begin
                r_ob_word[k] <= r_ob_word[k+1];
            end
            r_ob_word[NUM_WORDS-1] <= '0;
        end
    end

    assign o_m_tvalid = r_ob_valid;
    assign o_m_tdata  = {5'b00000, r_ob_idx, r_ob_word[0]};
    assign o_m_tuser  = r_ob_status;
    assign o_m_tlast  = (r_ob_idx == 3'd7);

    // after the eighth word the bus is idle or a new run starts at word 0
    a_run_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=>
            (!o_m_tvalid || o_m_tdata[66:64] == 3'd0))
        else $error("result run did not restart at word 0");

    // failed parses carry zero words
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_OK) |-> (o_m_tdata[63:0] == 64'd0))
        else $error("nonzero word with error status");

    // status is constant across a run
    a_status_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> $stable(o_m_tuser))
        else $error("status changed within a run");

endmodule
`default_nettype wire

[test/der_ecdsa_signature_parser_unit_tb.sv]
// Self-checking testbench for der_ecdsa_signature_parser_unit: directed signature
// table, then random DER frames, results checked against a built-in predictor.
// Depends on dersig_pkg and the parser RTL.
`timescale 1ns / 100ps
module der_ecdsa_signature_parser_unit_tb;
    import dersig_pkg::*;

    localparam int         CLK_PERIOD     = 10;
    localparam int         RESET_CYCLES   = 8;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         LIVE_BYTE_GOAL = 350;
    localparam int         QUIET_TAIL     = 60;   // live bytes at the end sent with no idling
    localparam int         NUM_ROWS       = 23;
    localparam int         REPORT_MAX     = 10;
    localparam int         DRAIN_CYCLES   = 20;
    localparam logic [7:0] NO_POKE        = 8'hFF;

    // one directed signature: two INTEGER TLVs plus optional damage
    typedef struct packed {
        logic [5:0] r_len;      // TLV length of r (content bytes)
        logic [7:0] r_lead;     // first content byte of r
        logic [7:0] r_next;     // second content byte of r
        logic [5:0] s_len;      // TLV length of s, 0 leaves s out
        logic [7:0] s_lead;
        logic [7:0] s_next;
        logic [7:0] fill;       // further content bytes count up from here
        logic [8:0] pad_bytes;  // bytes appended after s
        logic [1:0] cut_bytes;  // bytes dropped from the end
        logic [7:0] poke_at;    // byte overwritten after the length is sealed
        logic [7:0] poke_val;
        t_status    exp_status; // ST_OK: words and status from the predictor
    } t_sig_row;

    typedef struct packed {
        logic [71:0] tdata;
        t_status     status;
        logic        last;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // [7:0] data_byte
    logic        i_s_tlast;    // final_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;    // [63:0] value_word, [66:64] word_index, rest zero
    logic [3:0]  o_m_tuser;    // [3:0] status
    logic        o_m_tlast;    // run_end

    der_ecdsa_signature_parser_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state
    t_phase       parse_phase;
    int           frame_bytes;
    int           frame_seq_len;
    int           int_left;
    int           int_len_v;
    logic         on_s;
    t_status      first_fault;
    logic [255:0] r_value;
    logic [255:0] s_value;

    t_word        pending_words[$];
    logic [7:0]   frame_q[$];
    t_sig_row     dir_rows[NUM_ROWS];
    logic         use_typed;
    t_status      typed_status;
    logic         gaps_on;
    int           live_bytes;
    int           fail_count = 0;
    int           stall_left = 0;
    int unsigned  cycle_cnt = 0;
    t_word        due_w;

    function automatic t_sig_row mk_row(int r_len, logic [7:0] r_lead, logic [7:0] r_next,
                                        int s_len, logic [7:0] s_lead, logic [7:0] s_next,
                                        logic [7:0] fill, int pad, int cut,
                                        logic [7:0] poke_at, logic [7:0] poke_val,
                                        t_status exp_status);
        t_sig_row row;
        row.r_len      = 6'(r_len);
        row.r_lead     = r_lead;
        row.r_next     = r_next;
        row.s_len      = 6'(s_len);
        row.s_lead     = s_lead;
        row.s_next     = s_next;
        row.fill       = fill;
        row.pad_bytes  = 9'(pad);
        row.cut_bytes  = 2'(cut);
        row.poke_at    = poke_at;
        row.poke_val   = poke_val;
        row.exp_status = exp_status;
        return row;
    endfunction

    function void clear_parser();
        parse_phase   = PH_SEQ_TAG;
        frame_bytes   = 0;
        frame_seq_len = 0;
        int_left      = 0;
        int_len_v     = 0;
        on_s          = 1'b0;
        first_fault   = ST_OK;
        r_value       = '0;
        s_value       = '0;
    endfunction

    function void note_fault(t_status code);
        if (first_fault == ST_OK) first_fault = code;
        parse_phase = PH_DONE;
    endfunction

    // one value byte of r or s; closes the integer when its last byte is in
    function void absorb_digit(logic [7:0] b, int pos);
        if (on_s) s_value = {s_value[247:0], b};
        else      r_value = {r_value[247:0], b};
        if (int_left > 0) int_left--;
        if (int_left == 0) begin
            if (!on_s) begin
                // s needs at least tag, length and one byte before the buffer end
                if (pos + 3 >= frame_seq_len + 2) begin
                    note_fault(ST_INT_SHORT);
                end else begin
                    on_s        = 1'b1;
                    parse_phase = PH_INT_TAG;
                end
            end else if (pos + 1 != frame_seq_len + 2) begin
                note_fault(ST_TRAILING);
            end else begin
                parse_phase = PH_DONE;
            end
        end else begin
            parse_phase = PH_INT_REST;
        end
    endfunction

    // advance the predictor by one accepted byte, queue the run on a last byte
    function void decode_byte(logic [7:0] b, logic last);
        int      pos;
        t_status st;
        t_word   w;
        pos = frame_bytes;
        if (parse_phase != PH_DONE) live_bytes++;
        case (parse_phase)
            PH_SEQ_TAG: begin
                if (b != SEQ_TAG) note_fault(ST_SEQ_TAG);
                else parse_phase = PH_SEQ_LEN;
            end
            PH_SEQ_LEN: begin
                frame_seq_len = b;
                if (frame_seq_len + 2 <= 4) note_fault(ST_INT_SHORT);
                else parse_phase = PH_INT_TAG;
            end
            PH_INT_TAG: begin
                if (b != INT_TAG) note_fault(ST_INT_TAG);
                else parse_phase = PH_INT_LEN;
            end
            PH_INT_LEN: begin
                if (b < 1 || b > MAX_INT_LEN) begin
                    note_fault(ST_INT_LEN);
                end else if (pos + 1 + b > frame_seq_len + 2) begin
                    note_fault(ST_OVERRUN);
                end else begin
                    int_len_v   = b;
                    int_left    = b;
                    parse_phase = PH_INT_FIRST;
                end
            end
            PH_INT_FIRST: begin
                if (b != 8'd0) begin
                    if (b[7]) note_fault(ST_SIGN);
                    else if (int_len_v > INT_BYTES) note_fault(ST_TOO_BIG);
                    else absorb_digit(b, pos);
                end else if (int_len_v > 1) begin
                    // leading zero pad: must be followed by a byte with bit 7 set
                    int_left--;
                    parse_phase = PH_INT_SECOND;
                end else begin
                    absorb_digit(b, pos);
                end
            end
            PH_INT_SECOND: begin
                if (!b[7]) note_fault(ST_SIGN);
                else if (int_len_v - 1 > INT_BYTES) note_fault(ST_TOO_BIG);
                else absorb_digit(b, pos);
            end
            PH_INT_REST: absorb_digit(b, pos);
            default: ;
        endcase
        if (frame_bytes < 255) frame_bytes++;
        if (last) begin
            if (frame_bytes < MIN_SIG_BYTES || frame_bytes > MAX_SIG_BYTES) st = ST_SIZE;
            else if (first_fault == ST_SEQ_TAG)          st = ST_SEQ_TAG;
            else if (frame_seq_len != frame_bytes - 2)   st = ST_SEQ_LEN;
            else if (first_fault != ST_OK)               st = first_fault;
            else if (parse_phase != PH_DONE)             st = ST_TRAILING;
            else                                         st = ST_OK;
            if (use_typed) st = typed_status;
            for (int k = 0; k < NUM_WORDS; k++) begin
                w.tdata = '0;
                w.tdata[66:64] = k[2:0];
                if (st == ST_OK) begin
                    if (k < 4) w.tdata[63:0] = r_value[(3 - k) * 64 +: 64];
                    else       w.tdata[63:0] = s_value[(7 - k) * 64 +: 64];
                end
                w.status = st;
                w.last   = (k == NUM_WORDS - 1);
                pending_words.push_back(w);
            end
            clear_parser();
        end
    endfunction

    function void add_int_tlv(int len, logic [7:0] lead, logic [7:0] second,
                              logic [7:0] fill, logic noisy);
        logic [7:0] v;
        frame_q.push_back(INT_TAG);
        frame_q.push_back(len[7:0]);
        for (int i = 0; i < len; i++) begin
            v = fill + 8'(i);
            if (i == 0)      v = lead;
            else if (i == 1) v = second;
            else if (noisy)  v = 8'($urandom_range(0, 255));
            frame_q.push_back(v);
        end
    endfunction

    // well-formed INTEGER: mostly short values, some wide, some full 256 bits
    function void add_random_int();
        int         pick;
        int         nval;
        logic [7:0] v0;
        pick = $urandom_range(0, 19);
        if (pick < 12)      nval = $urandom_range(1, 8);
        else if (pick < 17) nval = $urandom_range(9, 31);
        else                nval = 32;
        v0 = (nval > 1) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255));
        if (v0[7]) add_int_tlv(nval + 1, 8'h00, v0, 8'h00, 1'b1);
        else       add_int_tlv(nval, v0, 8'($urandom_range(0, 255)), 8'h00, 1'b1);
    endfunction

    function void seal_length();
        frame_q[1] = 8'(frame_q.size() - 2);
    endfunction

    function void make_random_frame();
        int kind;
        int n;
        frame_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            // noise, half of it starting with a valid sequence tag
            n = $urandom_range(1, 24);
            repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1) frame_q[0] = SEQ_TAG;
        end else begin
            frame_q.push_back(SEQ_TAG);
            frame_q.push_back(8'h00);
            add_random_int();
            add_random_int();
            seal_length();
            if (kind >= 75) begin
                n = $urandom_range(0, 3);
                if (n == 0) begin
                    frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
                end else if (n == 1) begin
                    repeat ($urandom_range(1, 3)) frame_q.pop_back();
                end else begin
                    // extra bytes, either counted by the sequence length or not
                    repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
                    if (n == 3) seal_length();
                end
            end
        end
    endfunction

    // feed frame_q as one signature; tvalid stays high between back-to-back bytes
    task send_frame();
        for (int i = 0; i < frame_q.size(); i++) begin
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= frame_q[i];
            i_s_tlast  <= (i == frame_q.size() - 1);
            do @(posedge i_clk); while (o_s_tready !== 1'b1);
            decode_byte(frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    // result side: check each accepted word, then choose next tready
    always @(posedge i_clk) begin
        if (o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            if (pending_words.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: word with none expected: tdata %h tuser %0d tlast %b",
                             $time, o_m_tdata, o_m_tuser, o_m_tlast);
            end else begin
                due_w = pending_words.pop_front();
                if (o_m_tdata !== due_w.tdata || o_m_tuser !== due_w.status ||
                    o_m_tlast !== due_w.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: expected tdata %h tuser %0d tlast %b, got %h %0d %b",
                                 $time, due_w.tdata, due_w.status, due_w.last,
                                 o_m_tdata, o_m_tuser, o_m_tlast);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("der_ecdsa_signature_parser_unit test failed");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'h00;
        i_s_tlast  = 1'b0;
        gaps_on    = 1'b1;
        use_typed  = 1'b0;
        live_bytes = 0;
        clear_parser();

        //                   r: len lead   next   s: len lead   next   fill  pad cut poke
        dir_rows[0]  = mk_row(1,  8'h01, 8'h00, 1,  8'h7F, 8'h00, 8'h00, 0,   0, NO_POKE, 8'h00,
                              ST_OK);        // smallest legal frame, 8 bytes
        dir_rows[1]  = mk_row(33, 8'h00, 8'h80, 33, 8'h00, 8'hFF, 8'hA5, 0,   0, NO_POKE, 8'h00,
                              ST_OK);        // largest legal frame, 72 bytes
        dir_rows[2]  = mk_row(1,  8'h00, 8'h00, 1,  8'h00, 8'h00, 8'h00, 0,   0, NO_POKE, 8'h00,
                              ST_OK);        // r = s = 0
        dir_rows[3]  = mk_row(2,  8'h00, 8'h80, 2,  8'h00, 8'hFF, 8'h00, 0,   0, NO_POKE, 8'h00,
                              ST_OK);        // required zero pad
        dir_rows[4]  = mk_row(32, 8'h7F, 8'hFF, 32, 8'h01, 8'h00, 8'h3C, 0,   0, NO_POKE, 8'h00,
                              ST_OK);        // full 256-bit values without pad
        dir_rows[5]  = mk_row(1,  8'h01, 8'h00, 1,  8'h01, 8'h00, 8'h00, 0,   1, NO_POKE, 8'h00,
                              ST_SIZE);      // 7 bytes
        dir_rows[6]  = mk_row(33, 8'h00, 8'h80, 33, 8'h00, 8'h80, 8'h11, 1,   0, NO_POKE, 8'h00,
                              ST_SIZE);      // 73 bytes
        dir_rows[7]  = mk_row(1,  8'h01, 8'h00, 1,  8'h01, 8'h00, 8'h5A, 292, 0, NO_POKE, 8'h00,
                              ST_SIZE);      // 300 bytes, byte count saturates
        dir_rows[8]  = mk_row(1,  8'h01, 8'h00, 1,  8'h01, 8'h00, 8'h00, 0,   0, 8'd0,    8'h31,
                              ST_SEQ_TAG);
        dir_rows[9]  = mk_row(1,  8'h01, 8'h00, 1,  8'h01, 8'h00, 8'h00, 0,   1, 8'd0,    8'h00,
                              ST_SIZE);      // size outranks a bad tag
        dir_rows[10] = mk_row(1,  8'h01, 8'h00, 1,  8'h01, 8'h00, 8'h00, 0,   0, 8'd1,    8'h07,
                              ST_SEQ_LEN);
        dir_rows[11] = mk_row(1,  8'h01, 8'h00, 1,  8'h01, 8'h00, 8'h00, 0,   0, 8'd1,    8'h00,
                              ST_SEQ_LEN);   // zero length outranks the short-integer check
        dir_rows[12] = mk_row(3,  8'h01, 8'h02, 0,  8'h00, 8'h00, 8'h03, 1,   0, NO_POKE, 8'h00,
                              ST_INT_SHORT); // no room left for s
        dir_rows[13] = mk_row(1,  8'h01, 8'h00, 1,  8'h01, 8'h00, 8'h00, 0,   0, 8'd2,    8'h03,
                              ST_INT_TAG);
        dir_rows[14] = mk_row(1,  8'h01, 8'h00, 1,  8'h01, 8'h00, 8'h00, 0,   0, 8'd5,    8'h04,
                              ST_INT_TAG);   // bad tag on s
        dir_rows[15] = mk_row(1,  8'h01, 8'h00, 1,  8'h01, 8'h00, 8'h00, 0,   0, 8'd3,    8'h00,
                              ST_INT_LEN);   // zero-length integer
        dir_rows[16] = mk_row(1,  8'h01, 8'h00, 1,  8'h01, 8'h00, 8'h00, 0,   0, 8'd3,    8'd34,
                              ST_INT_LEN);   // integer longer than 33
        dir_rows[17] = mk_row(1,  8'h01, 8'h00, 4,  8'h01, 8'h02, 8'h10, 0,   1, NO_POKE, 8'h00,
                              ST_OVERRUN);   // s claims more than the buffer holds
        dir_rows[18] = mk_row(1,  8'h80, 8'h00, 1,  8'h01, 8'h00, 8'h00, 0,   0, NO_POKE, 8'h00,
                              ST_SIGN);      // negative r
        dir_rows[19] = mk_row(2,  8'h00, 8'h01, 1,  8'h01, 8'h00, 8'h00, 0,   0, NO_POKE, 8'h00,
                              ST_SIGN);      // needless zero pad
        dir_rows[20] = mk_row(1,  8'h01, 8'h00, 1,  8'hFF, 8'h00, 8'h00, 0,   0, NO_POKE, 8'h00,
                              ST_SIGN);      // negative s
        dir_rows[21] = mk_row(33, 8'h01, 8'h02, 1,  8'h01, 8'h00, 8'h20, 0,   0, NO_POKE, 8'h00,
                              ST_TOO_BIG);   // 33 value bytes without pad
        dir_rows[22] = mk_row(1,  8'h01, 8'h00, 1,  8'h01, 8'h00, 8'hEE, 1,   0, NO_POKE, 8'h00,
                              ST_TRAILING);  // byte after s inside the sequence

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            frame_q.delete();
            frame_q.push_back(SEQ_TAG);
            frame_q.push_back(8'h00);
            add_int_tlv(dir_rows[r].r_len, dir_rows[r].r_lead, dir_rows[r].r_next,
                        dir_rows[r].fill, 1'b0);
            if (dir_rows[r].s_len != 0)
                add_int_tlv(dir_rows[r].s_len, dir_rows[r].s_lead, dir_rows[r].s_next,
                            dir_rows[r].fill, 1'b0);
            for (int i = 0; i < dir_rows[r].pad_bytes; i++)
                frame_q.push_back(dir_rows[r].fill + 8'(i));
            repeat (dir_rows[r].cut_bytes) frame_q.pop_back();
            seal_length();
            if (dir_rows[r].poke_at != NO_POKE)
                frame_q[dir_rows[r].poke_at] = dir_rows[r].poke_val;
            use_typed    = (dir_rows[r].exp_status != ST_OK);
            typed_status = dir_rows[r].exp_status;
            send_frame();
        end

        // random frames; idling switched per frame, none over the last stretch
        use_typed  = 1'b0;
        live_bytes = 0;
        while (live_bytes < LIVE_BYTE_GOAL) begin
            gaps_on = (live_bytes < LIVE_BYTE_GOAL - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            make_random_frame();
            send_frame();
        end
        i_s_tvalid <= 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_words.size() == 0)
            $display("der_ecdsa_signature_parser_unit test passed");
        else
            $display("der_ecdsa_signature_parser_unit test failed");
        $finish;
    end

endmodule

[files.f]
rtl/dersig_pkg.sv
rtl/dersig_step.sv
rtl/der_ecdsa_signature_parser_unit.sv
test/der_ecdsa_signature_parser_unit_tb.sv
